// ===== src/combined_lcg_shuffle_rng_defines.svh =====
// Assertion macros for the combined LCG shuffle generator.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// same-cycle implication
`define CLSR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLSR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/clsr_pkg.sv =====
// Package for the combined LCG shuffle generator: widths, generator constants,
// controller/datapath command and status structs, and the modular fold function.
// No dependencies.
package clsr_pkg;

   localparam int VALUE_W        = 31;
   localparam int SEED_W         = 31;
   localparam int MUL_W          = 16;
   localparam int FOLD_W         = 8;
   localparam int PROD_W         = VALUE_W + MUL_W;
   localparam int TABLE_SIZE_DEF = 32;
   localparam int WARMUP_EXTRA   = 8;

   localparam logic [MUL_W-1:0]   MUL_A       = 16'd40014;
   localparam logic [MUL_W-1:0]   MUL_B       = 16'd40692;
   localparam logic [VALUE_W-1:0] MOD_A       = 31'd2147483563;
   localparam logic [VALUE_W-1:0] MOD_B       = 31'd2147483399;
   localparam logic [FOLD_W-1:0]  FOLD_A      = 8'd85;   // 2^31 - MOD_A
   localparam logic [FOLD_W-1:0]  FOLD_B      = 8'd249;  // 2^31 - MOD_B
   localparam logic [VALUE_W-1:0] SPAN_A      = 31'd2147483562;
   localparam logic [VALUE_W-1:0] GEN_A_RESET = 31'd1;
   localparam logic [VALUE_W-1:0] GEN_B_RESET = 31'd123456789;

   typedef struct packed {
      logic load_seed;
      logic mul_en;
      logic rd_en;
      logic red_a_en;
      logic red_b_en;
      logic warm_step;
      logic mix_en;
   } clsr_cmd_type;

   typedef struct packed {
      logic warm_last;
   } clsr_status_type;

   // p mod (2^31 - c): fold the high part back once, then one conditional subtract
   function automatic logic [VALUE_W-1:0] mod_fold(input logic [PROD_W-1:0]  p,
                                                   input logic [VALUE_W-1:0] m,
                                                   input logic [FOLD_W-1:0]  c);
      logic [VALUE_W:0] s;
      s = VALUE_W'(32'(p[PROD_W-1:VALUE_W]) * 32'(c)) + {1'b0, p[VALUE_W-1:0]};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[VALUE_W-1:0];
   endfunction

endpackage

// ===== src/clsr_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on clsr_pkg.
interface clsr_req_if
   import clsr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SEED_W-1:0]   seed;

   modport source (output valid, output kind, output seed, input ready);
   modport sink   (input valid, input kind, input seed, output ready);
endinterface

interface clsr_rsp_if
   import clsr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== src/clsr_ctrl.sv =====
// Controller FSM: sequences reseed warm-up and the multiply/fold/combine step,
// owns the response valid flag. Depends on clsr_pkg.
module clsr_ctrl
   import clsr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_kind,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   input  clsr_status_type status,
   output clsr_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_WARM_MUL = 6'b000010,
      ST_WARM_RED = 6'b000100,
      ST_STEP_MUL = 6'b001000,
      ST_STEP_RED = 6'b010000,
      ST_STEP_MIX = 6'b100000
   } clsr_state_type;

   clsr_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_seed = req_kind;
               state_in      = req_kind ? ST_WARM_MUL : ST_STEP_MUL;
            end
         end
         ST_WARM_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            cmd.red_a_en  = 1'b1;
            cmd.warm_step = 1'b1;
            state_in      = status.warm_last ? ST_STEP_MUL : ST_WARM_MUL;
         end
         ST_STEP_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.rd_en  = 1'b1;
            state_in   = ST_STEP_RED;
         end
         ST_STEP_RED: begin
            cmd.red_a_en = 1'b1;
            cmd.red_b_en = 1'b1;
            state_in     = ST_STEP_MIX;
         end
         ST_STEP_MIX: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.mix_en = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.mix_en | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/clsr_datapath.sv =====
// Datapath: two constant multiply/fold generators, shuffle table memory with
// valid bits, index decode, combine and response register. Depends on clsr_pkg.
module clsr_datapath
   import clsr_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  clsr_cmd_type        cmd,
   input  logic [SEED_W-1:0]   seed,
   output clsr_status_type     status,
   output logic [VALUE_W-1:0]  value
);

   localparam int     IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int     WARM_STEPS = TABLE_SIZE + WARMUP_EXTRA;
   localparam int     CNT_W      = $clog2(WARM_STEPS);
   localparam longint IDX_DIV    = 1 + longint'(SPAN_A) / longint'(TABLE_SIZE);

   logic [VALUE_W-1:0] gen_a_ff, gen_a_in;
   logic [VALUE_W-1:0] gen_b_ff, gen_b_in;
   logic [VALUE_W-1:0] last_out_ff, last_out_in;
   logic [VALUE_W-1:0] value_ff;
   logic [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] red_a, red_b, seed_eff;

   logic [VALUE_W-1:0] shuf_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] shuf_vld_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   logic [TABLE_SIZE-1:0] above;
   logic [IDX_W-1:0]      idx;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_W-1:0]    wr_data;
   logic [VALUE_W-1:0]    rd_val;
   logic signed [VALUE_W+1:0] diff;
   logic [VALUE_W-1:0]    mix;

   assign red_a    = mod_fold(prod_a_ff, MOD_A, FOLD_A);
   assign red_b    = mod_fold(prod_b_ff, MOD_B, FOLD_B);
   assign seed_eff = (seed == '0) ? VALUE_W'(1) : seed;

   // thermometer of last_out against the bucket boundaries
   assign above[0] = 1'b0;
   for (genvar k = 1; k < TABLE_SIZE; k++) begin : g_bound
      localparam longint BOUND = longint'(k) * IDX_DIV;
      assign above[k] = {1'b0, last_out_ff} >= 32'(BOUND);
   end

   always_comb begin
      idx = '0;
      for (int k = 1; k < TABLE_SIZE; k++) begin
         if (above[k]) begin
            idx = IDX_W'(k);
         end
      end
   end

   assign wr_en   = cmd.mix_en | (cmd.warm_step && (32'(cnt_ff) < 32'(TABLE_SIZE)));
   assign wr_addr = cmd.mix_en ? idx : cnt_ff[IDX_W-1:0];
   assign wr_data = cmd.mix_en ? gen_a_ff : red_a;

   assign rd_val = rd_vld_ff ? rd_data_ff : '0;
   always_comb begin
      diff = $signed({2'b00, rd_val}) - $signed({2'b00, gen_b_ff});
      if (diff < 1) begin
         diff = diff + $signed({2'b00, SPAN_A});
      end
      mix = diff[VALUE_W-1:0];
   end

   always_comb begin
      gen_a_in    = gen_a_ff;
      gen_b_in    = gen_b_ff;
      last_out_in = last_out_ff;
      cnt_in      = cnt_ff;
      if (cmd.load_seed) begin
         gen_a_in = seed_eff;
         gen_b_in = seed_eff;
         cnt_in   = CNT_W'(WARM_STEPS - 1);
      end
      if (cmd.red_a_en) begin
         gen_a_in = red_a;
      end
      if (cmd.red_b_en) begin
         gen_b_in = red_b;
      end
      if (cmd.warm_step) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (status.warm_last) begin
            last_out_in = red_a;
         end
      end
      if (cmd.mix_en) begin
         last_out_in = mix;
      end
   end

   assign status.warm_last = (cnt_ff == '0);
   assign value            = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff    <= GEN_A_RESET;
         gen_b_ff    <= GEN_B_RESET;
         last_out_ff <= '0;
         cnt_ff      <= '0;
         shuf_vld_ff <= '0;
      end else begin
         gen_a_ff    <= gen_a_in;
         gen_b_ff    <= gen_b_in;
         last_out_ff <= last_out_in;
         cnt_ff      <= cnt_in;
         if (wr_en) begin
            shuf_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_a_ff <= PROD_W'(gen_a_ff) * PROD_W'(MUL_A);
         prod_b_ff <= PROD_W'(gen_b_ff) * PROD_W'(MUL_B);
      end
      if (cmd.mix_en) begin
         value_ff <= mix;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shuf_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= shuf_mem[idx];
         rd_vld_ff  <= shuf_vld_ff[idx];
      end
   end

endmodule

// ===== src/combined_lcg_shuffle_rng.sv =====
// Combined two-modulus multiplicative congruential generator (moduli 2147483563
// and 2147483399) with a TABLE_SIZE-entry Bays-Durham shuffle. Each request
// transaction (kind 0 = next number, kind 1 = reseed from seed, 0 taken as 1,
// then next number) yields one response transaction carrying value in
// 1..2147483562; value / 2147483563 is the uniform fraction. A plain request
// runs from the idle state that takes it through a multiply state and a fold
// state for the generator step and a combine state, which waits while a
// previous result is still pending, then returns to idle. A reseed first runs
// the table warm-up through the same multiply/fold state loop. The response
// sits in an output register, so a request is taken while a result waits.
// Depends on clsr_pkg, clsr_if, clsr_ctrl, clsr_datapath and the defines header.
`include "combined_lcg_shuffle_rng_defines.svh"

module combined_lcg_shuffle_rng
   import clsr_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   clsr_req_if.sink   req_chan,
   clsr_rsp_if.source rsp_chan
);

   clsr_cmd_type    cmd;
   clsr_status_type status;

   clsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   clsr_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .seed   (req_chan.seed),
      .status (status),
      .value  (rsp_chan.value)
   );

   `CLSR_ASSERT_IMP(a_no_overwrite, cmd.mix_en, (!rsp_chan.valid || rsp_chan.ready), "result overwritten while pending")
   `CLSR_ASSERT_NXT(a_one_at_a_time, (req_chan.valid && req_chan.ready), !req_chan.ready, "second transaction taken during work")
   `CLSR_ASSERT_NXT(a_step_start, (req_chan.valid && req_chan.ready && !req_chan.kind), cmd.mul_en, "step did not follow plain request")
   `CLSR_ASSERT_IMP(a_single_op, 1'b1, $onehot0({cmd.mul_en, cmd.red_a_en, cmd.mix_en}), "overlapping datapath operations")

endmodule

// ===== test/combined_lcg_shuffle_rng_tb.sv =====
// Testbench for combined_lcg_shuffle_rng: a queue-fed driver and a monitor check each response
// transaction against a predictor of the two-generator shuffle scheme.
// Depends on clsr_pkg, clsr_if and the combined_lcg_shuffle_rng top level.
module combined_lcg_shuffle_rng_tb;
   import clsr_pkg::*;

   typedef enum logic {KIND_NEXT = 1'b0, KIND_RESEED = 1'b1} req_kind_type;

   typedef struct {
      logic              kind;
      logic [SEED_W-1:0] seed;
      bit                drain;
      bit                calm;
   } req_item_type;

   localparam int              N_TABLE       = TABLE_SIZE_DEF;
   localparam int              N_RANDOM      = 1225;
   localparam int              CALM_TAIL     = 150;
   localparam int              SETTLE_CYCLES = 2 * (N_TABLE + WARMUP_EXTRA) + 40;
   localparam longint unsigned IDX_DIV       = 1 + 64'(SPAN_A) / N_TABLE;
   localparam longint          SPAN_L        = 64'(SPAN_A);
   localparam logic [SEED_W-1:0] SEED_ALL1   = 31'h7FFF_FFFF;
   localparam logic [SEED_W-1:0] SEED_ALT_A  = 31'h2AAA_AAAA;
   localparam logic [SEED_W-1:0] SEED_ALT_B  = 31'h5555_5555;

   logic clock;
   logic reset;

   clsr_req_if req_if ();
   clsr_rsp_if rsp_if ();

   combined_lcg_shuffle_rng i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predictor state
   logic [VALUE_W-1:0] pred_a;
   logic [VALUE_W-1:0] pred_b;
   logic [VALUE_W-1:0] pred_prev;
   logic [VALUE_W-1:0] pred_table [N_TABLE];

   req_item_type       pending_reqs [$];
   logic [VALUE_W-1:0] expected_values [$];

   logic req_fire;
   bit   quiet;
   int   req_gap;
   int   rsp_gap;
   int   n_errors;
   int   n_accepted;
   int   n_reseeds;
   int   n_results;

   always #1 clock = ~clock;

   function automatic logic [VALUE_W-1:0] lcg_step(input logic [VALUE_W-1:0] x,
                                                   input longint unsigned mul,
                                                   input longint unsigned modulus);
      longint unsigned p;
      p = (64'(x) * mul) % modulus;
      return p[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] rng_predict(input logic kind,
                                                      input logic [SEED_W-1:0] seed);
      logic [VALUE_W-1:0] s;
      longint unsigned    idx;
      longint             ta;
      longint             tb;
      longint             mix;
      if (kind == KIND_RESEED) begin
         s = (seed == '0) ? 31'd1 : seed;
         pred_a = s;
         pred_b = s;
         for (int j = N_TABLE + WARMUP_EXTRA - 1; j >= 0; j--) begin
            pred_a = lcg_step(pred_a, 64'(MUL_A), 64'(MOD_A));
            if (j < N_TABLE) begin
               pred_table[j] = pred_a;
            end
         end
         pred_prev = pred_table[0];
      end
      pred_a = lcg_step(pred_a, 64'(MUL_A), 64'(MOD_A));
      pred_b = lcg_step(pred_b, 64'(MUL_B), 64'(MOD_B));
      idx = 64'(pred_prev) / IDX_DIV;
      if (idx >= N_TABLE) begin
         idx = 64'(N_TABLE - 1);
      end
      ta = 64'(pred_table[idx]);
      tb = 64'(pred_b);
      mix = ta - tb;
      pred_table[idx] = pred_a;
      if (mix < 1) begin
         mix = mix + SPAN_L;
      end
      pred_prev = mix[VALUE_W-1:0];
      return pred_prev;
   endfunction

   task automatic add_req(input logic kind, input logic [SEED_W-1:0] seed, input bit drain);
      req_item_type it;
      it.kind  = kind;
      it.seed  = seed;
      it.drain = drain;
      it.calm  = 1'b0;
      pending_reqs.push_back(it);
   endtask

   // acceptance, prediction and response checking
   always @(posedge clock) begin : acc_mon
      logic [VALUE_W-1:0] want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (expected_values.size() == 0) begin
               $error("value: no transaction expected, actual 0x%08h", rsp_if.value);
               n_errors++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_if.value !== want) begin
                  $error("value: expected 0x%08h, actual 0x%08h", want, rsp_if.value);
                  n_errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            n_accepted++;
            if (req_if.kind == KIND_RESEED) begin
               n_reseeds++;
            end
            expected_values.push_back(rng_predict(req_if.kind, req_if.seed));
         end
      end
   end

   // request driver
   always @(negedge clock) begin : req_drive
      req_item_type it;
      logic         v;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_fire)) begin
         v = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_values.size() > 0)) begin
            it = pending_reqs.pop_front();
            v  = 1'b1;
            req_if.kind <= it.kind;
            req_if.seed <= it.seed;
            quiet       <= it.calm;
            if (!it.calm && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 11);
            end
         end
         req_if.valid <= v;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(1, 11);
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stim
      logic              kind;
      logic [SEED_W-1:0] seed;
      int                r;
      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind  = KIND_NEXT;
      req_if.seed  = '0;
      rsp_if.ready = 1'b0;
      quiet        = 1'b0;
      req_gap      = 0;
      rsp_gap      = 0;
      n_errors     = 0;
      n_accepted   = 0;
      n_reseeds    = 0;
      n_results    = 0;
      pred_a       = GEN_A_RESET;
      pred_b       = GEN_B_RESET;
      pred_prev    = '0;
      foreach (pred_table[i]) pred_table[i] = '0;

      // draws from the reset state, seed ignored
      add_req(KIND_NEXT, '0, 1'b0);
      add_req(KIND_NEXT, SEED_ALL1, 1'b0);
      add_req(KIND_NEXT, SEED_ALT_A, 1'b0);
      // zero seed taken as one
      add_req(KIND_RESEED, '0, 1'b1);
      add_req(KIND_NEXT, SEED_ALT_B, 1'b0);
      add_req(KIND_RESEED, 31'd1, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      add_req(KIND_RESEED, SPAN_A, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      // seed equal to the first modulus: first generator stuck at zero
      add_req(KIND_RESEED, MOD_A, 1'b1);
      add_req(KIND_NEXT, '0, 1'b0);
      add_req(KIND_NEXT, SEED_ALL1, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      // seed equal to the second modulus: second generator stuck at zero
      add_req(KIND_RESEED, MOD_B, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      // seed above the range, then alternating-bit seeds
      add_req(KIND_RESEED, SEED_ALL1, 1'b0);
      add_req(KIND_NEXT, '0, 1'b0);
      add_req(KIND_RESEED, SEED_ALT_A, 1'b0);
      add_req(KIND_RESEED, SEED_ALT_B, 1'b0);
      add_req(KIND_NEXT, SEED_ALL1, 1'b0);

      for (int i = 0; i < N_RANDOM; i++) begin
         r    = $urandom_range(0, 99);
         kind = (r < 7) ? KIND_RESEED : KIND_NEXT;
         if (kind == KIND_RESEED) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               seed = SEED_W'($urandom_range(0, SPAN_A));
            end else if (r < 95) begin
               seed = SEED_W'($urandom);
            end else begin
               case ($urandom_range(0, 4))
                  0: seed = '0;
                  1: seed = SPAN_A;
                  2: seed = MOD_A;
                  3: seed = MOD_B;
                  default: seed = SEED_ALL1;
               endcase
            end
         end else begin
            seed = SEED_W'($urandom);
         end
         add_req(kind, seed, $urandom_range(0, 149) == 0);
      end
      for (int i = pending_reqs.size() - CALM_TAIL; i < pending_reqs.size(); i++) begin
         pending_reqs[i].calm = 1'b1;
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_if.valid) @(negedge clock);
      while (expected_values.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d request transactions (%0d reseeds) and %0d responses,",
               n_accepted, n_reseeds, n_results);
      $display("including zero and out-of-range seeds and draws before any reseed.");
      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/clsr_pkg.sv
src/clsr_if.sv
src/clsr_ctrl.sv
src/clsr_datapath.sv
src/combined_lcg_shuffle_rng.sv
test/combined_lcg_shuffle_rng_tb.sv
